@@ src/at_response_data_frame_parser_macros.svh @@
// Assertion macros shared by the parser modules
`ifndef AT_RESPONSE_DATA_FRAME_PARSER_MACROS_SVH
`define AT_RESPONSE_DATA_FRAME_PARSER_MACROS_SVH

// Condition must hold on every clock edge out of reset
`define ATPAR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("parser check failed");

// Antecedent implies consequent in the same cycle
`define ATPAR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("parser check failed");

// Antecedent implies consequent in the following cycle
`define ATPAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

@@ src/atpar_pkg.sv @@
// Shared types and constants for the AT response data frame parser
package atpar_pkg;

    // Payload limit and counter widths
    localparam int MAX_PAYLOAD = 256;
    localparam int CNT_W       = 9;
    localparam int LEN_W       = 16;
    localparam int LINK_W      = 4;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Character codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_THREE = 8'h33;

    // Header patterns, oldest byte in the top bits
    localparam logic [39:0] HDR_IPD  = "+IPD,";
    localparam logic [39:0] HDR_ATUS = "ATUS:";

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Parse modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_LINK   = 3'd1,
        MODE_LEN    = 3'd2,
        MODE_DATA   = 3'd3,
        MODE_STDIG  = 3'd4,
        MODE_STSKIP = 3'd5
    } mode_t;

    // Classified byte carried through the queue
    typedef struct packed {
        logic [7:0]        rx_byte;
        logic              is_digit;
        logic [LINK_W-1:0] digit;
        logic              is_comma;
        logic              is_colon;
        logic              is_three;
    } item_t;

endpackage

@@ src/atpar_front.sv @@
// Front end: accepts received bytes and classifies them for the queue
module atpar_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                q_wr_en,
    output atpar_pkg::item_t    q_wr_item,
    input  logic                q_wr_ready
);

    logic [7:0] diff;

    // Transaction goes straight into the queue when it has room
    assign s_ready = q_wr_ready;
    assign q_wr_en = s_valid && q_wr_ready;

    // Character classification
    always_comb begin
        diff               = s_rx_byte - atpar_pkg::CHAR_ZERO;
        q_wr_item.rx_byte  = s_rx_byte;
        q_wr_item.is_digit = (s_rx_byte >= atpar_pkg::CHAR_ZERO) &&
                             (s_rx_byte <= atpar_pkg::CHAR_NINE);
        q_wr_item.digit    = diff[atpar_pkg::LINK_W-1:0];
        q_wr_item.is_comma = (s_rx_byte == atpar_pkg::CHAR_COMMA);
        q_wr_item.is_colon = (s_rx_byte == atpar_pkg::CHAR_COLON);
        q_wr_item.is_three = (s_rx_byte == atpar_pkg::CHAR_THREE);
    end

endmodule

@@ src/atpar_fifo.sv @@
// Short queue of classified bytes between front and back
`include "at_response_data_frame_parser_macros.svh"

module atpar_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  atpar_pkg::item_t    wr_item,
    output logic                wr_ready,
    input  logic                rd_en,
    output logic                rd_valid,
    output atpar_pkg::item_t    rd_item
);

    atpar_pkg::item_t                mem_reg [atpar_pkg::FIFO_DEPTH];
    logic [atpar_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [atpar_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [atpar_pkg::FIFO_AW:0]     count_reg, count_next;
    logic                            push, pop;

    assign wr_ready = (count_reg != (atpar_pkg::FIFO_AW+1)'(atpar_pkg::FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_en && wr_ready;
    assign pop      = rd_en && rd_valid;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `ATPAR_ASSERT_ALWAYS(a_count_bound, aclk, aresetn,
        count_reg <= (atpar_pkg::FIFO_AW+1)'(atpar_pkg::FIFO_DEPTH))
    `ATPAR_ASSERT_IMPLIES(a_pop_needs_data, aclk, aresetn, rd_en, count_reg != '0)
    `ATPAR_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 1'b1)

endmodule

@@ src/atpar_back.sv @@
// Back end: parse state machine, link status and result output register
`include "at_response_data_frame_parser_macros.svh"

module atpar_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             q_valid,
    input  atpar_pkg::item_t                 q_item,
    output logic                             q_rd_en,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_result_kind,
    output logic [7:0]                       m_payload_byte,
    output logic                             m_last_of_message,
    output logic [atpar_pkg::LEN_W-1:0]      m_declared_length,
    output logic [atpar_pkg::LINK_W-1:0]     m_link_id,
    output logic                             m_link_up
);

    atpar_pkg::mode_t                mode_reg, mode_next;
    logic [39:0]                     window_reg, window_next, window_shift;
    logic [atpar_pkg::LEN_W-1:0]     length_reg, length_next;
    logic [atpar_pkg::CNT_W-1:0]     count_reg, count_next, count_inc;
    logic [atpar_pkg::LINK_W-1:0]    link_reg, link_next;
    logic                            status_reg, status_next;
    logic                            mux_enabled_reg;

    logic                            out_valid_reg, out_valid_next;
    logic                            out_kind_reg, out_kind_next;
    logic [7:0]                      out_byte_reg, out_byte_next;
    logic                            out_last_reg, out_last_next;
    logic [atpar_pkg::LEN_W-1:0]     out_len_reg, out_len_next;
    logic [atpar_pkg::LINK_W-1:0]    out_link_reg, out_link_next;
    logic                            out_up_reg, out_up_next;

    logic                            pop, data_last;
    logic [19:0]                     len_sum;

    // Pop a byte whenever the output slot is free or draining this cycle
    assign pop     = q_valid && (!out_valid_reg || m_ready);
    assign q_rd_en = pop;

    // Shared datapath terms
    always_comb begin
        window_shift = {window_reg[31:0], q_item.rx_byte};
        count_inc    = count_reg + 1'b1;
        data_last    = ({{(atpar_pkg::LEN_W-atpar_pkg::CNT_W){1'b0}}, count_inc} == length_reg)
                    || (count_inc >= atpar_pkg::CNT_W'(atpar_pkg::MAX_PAYLOAD));
        len_sum      = {1'b0, length_reg, 3'b000} + {3'b000, length_reg, 1'b0}
                     + {16'd0, q_item.digit};
    end

    // Next parse mode
    always_comb begin
        mode_next = mode_reg;
        if (pop) begin
            unique case (mode_reg)
                atpar_pkg::MODE_STDIG: begin
                    mode_next = atpar_pkg::MODE_STSKIP;
                end
                atpar_pkg::MODE_STSKIP: begin
                    if (q_item.is_comma || !status_reg) begin
                        mode_next = atpar_pkg::MODE_IDLE;
                    end
                end
                atpar_pkg::MODE_LINK: begin
                    if (q_item.is_comma) begin
                        mode_next = atpar_pkg::MODE_LEN;
                    end
                end
                atpar_pkg::MODE_LEN: begin
                    if (q_item.is_colon) begin
                        mode_next = atpar_pkg::MODE_DATA;
                    end
                end
                atpar_pkg::MODE_DATA: begin
                    if (data_last) begin
                        mode_next = atpar_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    if (window_shift == atpar_pkg::HDR_IPD) begin
                        mode_next = mux_enabled_reg ? atpar_pkg::MODE_LINK
                                                    : atpar_pkg::MODE_LEN;
                    end else if (window_shift == atpar_pkg::HDR_ATUS) begin
                        mode_next = atpar_pkg::MODE_STDIG;
                    end else begin
                        mode_next = atpar_pkg::MODE_IDLE;
                    end
                end
            endcase
        end
    end

    // Datapath and result register
    always_comb begin
        window_next    = window_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        link_next      = link_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_len_next   = out_len_reg;
        out_link_next  = out_link_reg;
        out_up_next    = out_up_reg;
        if (pop) begin
            if (mode_reg != atpar_pkg::MODE_STDIG && mode_reg != atpar_pkg::MODE_STSKIP) begin
                window_next = window_shift;
            end
            unique case (mode_reg)
                atpar_pkg::MODE_STDIG: begin
                    status_next    = q_item.is_three;
                    out_valid_next = 1'b1;
                    out_kind_next  = atpar_pkg::KIND_STATUS;
                    out_byte_next  = '0;
                    out_last_next  = 1'b0;
                    out_len_next   = length_reg;
                    out_link_next  = link_reg;
                    out_up_next    = q_item.is_three;
                end
                atpar_pkg::MODE_LINK: begin
                    if (!q_item.is_comma) begin
                        link_next = q_item.is_digit ? q_item.digit : '0;
                    end
                end
                atpar_pkg::MODE_LEN: begin
                    if (q_item.is_digit) begin
                        length_next = (len_sum[19:16] != 4'd0) ? '1 : len_sum[15:0];
                    end
                end
                atpar_pkg::MODE_DATA: begin
                    out_valid_next = 1'b1;
                    out_kind_next  = atpar_pkg::KIND_PAYLOAD;
                    out_byte_next  = q_item.rx_byte;
                    out_last_next  = data_last;
                    out_len_next   = length_reg;
                    out_link_next  = link_reg;
                    out_up_next    = status_reg;
                    if (data_last) begin
                        length_next = '0;
                        count_next  = '0;
                    end else begin
                        count_next  = count_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= atpar_pkg::MODE_IDLE;
            window_reg      <= '0;
            length_reg      <= '0;
            count_reg       <= '0;
            link_reg        <= '0;
            status_reg      <= 1'b0;
            mux_enabled_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            mode_reg        <= mode_next;
            window_reg      <= window_next;
            length_reg      <= length_next;
            count_reg       <= count_next;
            link_reg        <= link_next;
            status_reg      <= status_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en) begin
                mux_enabled_reg <= cfg_wr_data;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_len_reg  <= out_len_next;
        out_link_reg <= out_link_next;
        out_up_reg   <= out_up_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_result_kind     = out_kind_reg;
    assign m_payload_byte    = out_byte_reg;
    assign m_last_of_message = out_last_reg;
    assign m_declared_length = out_len_reg;
    assign m_link_id         = out_link_reg;
    assign m_link_up         = out_up_reg;

    `ATPAR_ASSERT_IMPLIES(a_status_clean, aclk, aresetn,
        out_valid_reg && out_kind_reg == atpar_pkg::KIND_STATUS,
        !out_last_reg && out_byte_reg == 8'd0)
    `ATPAR_ASSERT_IMPLIES(a_count_limit, aclk, aresetn,
        mode_reg == atpar_pkg::MODE_DATA,
        count_reg < atpar_pkg::CNT_W'(atpar_pkg::MAX_PAYLOAD))
    `ATPAR_ASSERT_NEXT(a_data_gives_result, aclk, aresetn,
        pop && mode_reg == atpar_pkg::MODE_DATA, out_valid_reg)

endmodule

@@ src/at_response_data_frame_parser.sv @@
// Top level of the AT response data frame parser
//
// Takes one received byte per transaction and returns at most one result per byte: a payload
// byte of an "+IPD," frame or a link status update after "ATUS:". One byte is accepted every
// cycle while the four-entry queue has room; a byte is popped by the parse state machine in
// the back end whenever the result register is empty or being taken, so while results are
// taken the sustained rate is one byte per cycle. An accepted byte passes through a queue
// entry, then the result register. The single configuration bit selects multiplexed mode,
// in which a link id precedes the length; write it only while the parser is idle.
module at_response_data_frame_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_result_kind,
    output logic [7:0]                       m_payload_byte,
    output logic                             m_last_of_message,
    output logic [atpar_pkg::LEN_W-1:0]      m_declared_length,
    output logic [atpar_pkg::LINK_W-1:0]     m_link_id,
    output logic                             m_link_up
);

    logic             q_wr_en, q_wr_ready, q_rd_en, q_rd_valid;
    atpar_pkg::item_t q_wr_item, q_rd_item;

    // Classifier on the receive side
    atpar_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .q_wr_en    (q_wr_en),
        .q_wr_item  (q_wr_item),
        .q_wr_ready (q_wr_ready)
    );

    // Decoupling queue
    atpar_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_item  (q_wr_item),
        .wr_ready (q_wr_ready),
        .rd_en    (q_rd_en),
        .rd_valid (q_rd_valid),
        .rd_item  (q_rd_item)
    );

    // Parser and result register
    atpar_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .q_valid           (q_rd_valid),
        .q_item            (q_rd_item),
        .q_rd_en           (q_rd_en),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_payload_byte    (m_payload_byte),
        .m_last_of_message (m_last_of_message),
        .m_declared_length (m_declared_length),
        .m_link_id         (m_link_id),
        .m_link_up         (m_link_up)
    );

endmodule
